// ===== rtl/tsdq_pkg.sv =====
// ----------------------------------------------------------------------------
// tsdq_pkg
// Shared types and constants of the timed semaphore deadline queue.
// ----------------------------------------------------------------------------
`default_nettype none
package tsdq_pkg;

    localparam int QueueDepthDefault = 16;
    localparam int TimeWidth = 48;
    localparam int CountWidth = 16;
    localparam int InitWidth = 15;
    localparam logic signed [CountWidth-1:0] CountMax = 16'sd32767;

    typedef enum logic [2:0] {
        ACT_WAIT   = 3'd0,
        ACT_TWAIT  = 3'd1,
        ACT_SIGNAL = 3'd2,
        ACT_TRY    = 3'd3,
        ACT_CLOSE  = 3'd4,
        ACT_TICK   = 3'd5,
        ACT_OPEN   = 3'd6,
        ACT_NONE   = 3'd7
    } action_t;

    typedef enum logic [2:0] {
        ST_SUCCESS  = 3'd0,
        ST_UNLOCKED = 3'd1,
        ST_DEAD     = 3'd2,
        ST_TIMEOUT  = 3'd3,
        ST_BLOCKED  = 3'd4,
        ST_FULL     = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACK,
        S_SCAN,
        S_SHIFT,
        S_POP,
        S_REL,
        S_EMIT
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic    load;        // latch input word and apply the ack-phase update
        logic    scan_start;  // clear scan index (insertion search)
        logic    scan_step;   // advance insertion search by one entry
        logic    shift_step;  // move one entry up toward the free slot
        logic    insert;      // write the new waiter at the insertion slot
        logic    pop;         // remove head, shifting one entry per cycle
        logic    emit_ack;    // present acknowledgement word
        logic    emit_rel;    // present release word
        logic    tick_adjust; // give back one count per expired waiter
        status_t rel_status;
        logic    rel_last;
    } dp_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        action_t act;
        logic    enqueue;     // ack phase decided to queue the caller
        logic    sig_release; // signal releases the head waiter
        logic    queue_empty;
        logic    head_expired;
        logic    scan_done;
        logic    shift_done;
        logic    pop_done;
        logic    out_busy;
        logic    rel_final;   // the next release is the last of the action
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/tsdq_if.sv =====
// ----------------------------------------------------------------------------
// tsdq_in_if / tsdq_out_if
// Valid/ready channels carrying the input and result words.
// ----------------------------------------------------------------------------
`default_nettype none
interface tsdq_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [7:0]  thread_id;
    logic [31:0] wait_ticks;
    modport source (output valid, action, thread_id, wait_ticks, input ready);
    modport sink (input valid, action, thread_id, wait_ticks, output ready);
endinterface

interface tsdq_out_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [7:0]         thread_id_out;
    logic [2:0]         status;
    logic signed [15:0] count_now;
    logic               last;
    modport source (output valid, kind, thread_id_out, status, count_now, last,
                    input ready);
    modport sink (input valid, kind, thread_id_out, status, count_now, last,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/tsdq_dp.sv =====
// ----------------------------------------------------------------------------
// tsdq_dp
// Datapath: semaphore count, clock, register-file queue and output register.
// ----------------------------------------------------------------------------
`default_nettype none
module tsdq_dp #(
    parameter int QUEUE_DEPTH = tsdq_pkg::QueueDepthDefault
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [tsdq_pkg::InitWidth-1:0]   cfg_data,
    input  wire logic [2:0]                       in_action,
    input  wire logic [7:0]                       in_thread,
    input  wire logic [31:0]                      in_ticks,
    input  wire tsdq_pkg::dp_cmd_t                cmd,
    input  wire logic                             idx_to_tail,
    output tsdq_pkg::dp_stat_t                    stat,
    tsdq_out_if.source                            res
);
    import tsdq_pkg::*;

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int TW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [TW-1:0] Full = TW'(QUEUE_DEPTH);

    logic [InitWidth-1:0]         init_reg;
    logic signed [CountWidth-1:0] count_reg;
    logic                         closed_reg;
    logic [TimeWidth-1:0]         time_reg;
    logic [TW-1:0]                total_reg;
    logic [7:0]                   q_thread [QUEUE_DEPTH];
    logic [TimeWidth-1:0]         q_dl [QUEUE_DEPTH];
    logic                         q_fv [QUEUE_DEPTH];

    action_t        act_reg;
    logic [7:0]     tid_reg;
    logic [TimeWidth-1:0] dl_reg;
    logic           enq_reg;
    logic           sigrel_reg;
    status_t        ack_st_reg;
    logic [TW-1:0]  idx_reg;    // scan/shift/pop position
    logic           found_reg;

    logic           ovalid_reg;
    logic           okind_reg;
    logic [7:0]     otid_reg;
    status_t        ost_reg;
    logic           olast_reg;

    logic [TW-1:0] dl_pos;   // insertion slot, latched at end of scan
    logic [TW-1:0] pos_reg;
    assign dl_pos = pos_reg;

    logic [IW-1:0]  ix;
    logic [IW-1:0]  ixm1;
    logic [IW-1:0]  ixp1;
    assign ix   = idx_reg[IW-1:0];
    assign ixm1 = IW'(idx_reg - TW'(1));
    assign ixp1 = IW'(idx_reg + TW'(1));

    assign stat.act          = act_reg;
    assign stat.enqueue      = enq_reg;
    assign stat.sig_release  = sigrel_reg;
    assign stat.queue_empty  = (total_reg == '0);
    assign stat.head_expired = (total_reg != '0) && !q_fv[0] && (q_dl[0] <= time_reg);
    assign stat.scan_done    = found_reg || (idx_reg == total_reg);
    assign stat.shift_done   = (idx_reg == dl_pos);
    assign stat.pop_done     = (idx_reg + TW'(1) >= total_reg);
    assign stat.out_busy     = ovalid_reg && !res.ready;
    // A tick counts down its expired waiters; close empties the whole queue.
    assign stat.rel_final    = (act_reg == ACT_TICK) ? (pos_reg == TW'(1))
                               : ((act_reg == ACT_SIGNAL) || (total_reg == TW'(1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg   <= '0;
            count_reg  <= '0;
            closed_reg <= 1'b0;
            time_reg   <= '0;
            total_reg  <= '0;
            ovalid_reg <= 1'b0;
            act_reg    <= ACT_NONE;
            enq_reg    <= 1'b0;
            sigrel_reg <= 1'b0;
            idx_reg    <= '0;
            found_reg  <= 1'b0;
            pos_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
                init_reg <= cfg_data;
            if (cmd.emit_ack || cmd.emit_rel)
                ovalid_reg <= 1'b1;
            else if (ovalid_reg && res.ready)
                ovalid_reg <= 1'b0;

            if (cmd.load)
            begin
                act_reg    <= action_t'(in_action);
                tid_reg    <= in_thread;
                dl_reg     <= time_reg + TimeWidth'(in_ticks);
                enq_reg    <= 1'b0;
                sigrel_reg <= 1'b0;
                ack_st_reg <= ST_SUCCESS;
                unique case (action_t'(in_action))
                    ACT_WAIT, ACT_TWAIT:
                    begin
                        if (closed_reg)
                            ack_st_reg <= ST_DEAD;
                        else if (count_reg > 0)
                            count_reg <= count_reg - 16'sd1;
                        else if (total_reg >= Full)
                            ack_st_reg <= ST_FULL;
                        else
                        begin
                            count_reg  <= count_reg - 16'sd1;
                            ack_st_reg <= ST_BLOCKED;
                            enq_reg    <= 1'b1;
                        end
                    end
                    ACT_SIGNAL:
                    begin
                        if (closed_reg)
                            ack_st_reg <= ST_DEAD;
                        if (count_reg < CountMax)
                        begin
                            count_reg <= count_reg + 16'sd1;
                            sigrel_reg <= (count_reg + 16'sd1 <= 0) && (total_reg != '0);
                        end
                    end
                    ACT_TRY:
                    begin
                        if (closed_reg)
                            ack_st_reg <= ST_DEAD;
                        else if (count_reg > 0)
                        begin
                            count_reg  <= count_reg - 16'sd1;
                            ack_st_reg <= ST_UNLOCKED;
                        end
                    end
                    ACT_CLOSE: closed_reg <= 1'b1;
                    ACT_TICK:  time_reg <= time_reg + TimeWidth'(1);
                    ACT_OPEN:
                    begin
                        count_reg  <= CountWidth'(init_reg);
                        closed_reg <= 1'b0;
                        total_reg  <= '0;
                    end
                    default: ;
                endcase
            end

            // A tick searches with the new time: the first entry that is
            // untimed or later than now ends the run of expired waiters.
            if (cmd.scan_start)
            begin
                idx_reg   <= '0;
                found_reg <= (act_reg == ACT_WAIT);
                pos_reg   <= total_reg;
                if (act_reg == ACT_TICK)
                    dl_reg <= time_reg;
            end
            else if (cmd.scan_step)
            begin
                if (q_fv[ix] || dl_reg < q_dl[ix])
                begin
                    found_reg <= 1'b1;
                    pos_reg   <= idx_reg;
                end
                else
                    idx_reg <= idx_reg + TW'(1);
            end

            if (idx_to_tail)
                idx_reg <= total_reg;

            if (cmd.tick_adjust)
                count_reg <= count_reg + signed'(CountWidth'(pos_reg));

            if (cmd.shift_step)
            begin
                q_thread[ix] <= q_thread[ixm1];
                q_dl[ix]     <= q_dl[ixm1];
                q_fv[ix]     <= q_fv[ixm1];
                idx_reg      <= idx_reg - TW'(1);
            end

            if (cmd.insert)
            begin
                q_thread[dl_pos[IW-1:0]] <= tid_reg;
                q_dl[dl_pos[IW-1:0]]     <= dl_reg;
                q_fv[dl_pos[IW-1:0]]     <= (act_reg == ACT_WAIT);
                total_reg                <= total_reg + TW'(1);
            end

            if (cmd.emit_rel)
            begin
                otid_reg <= q_thread[0];
                idx_reg  <= '0;
                if (act_reg == ACT_TICK)
                    pos_reg <= pos_reg - TW'(1);
            end

            if (cmd.pop)
            begin
                if (idx_reg + TW'(1) < total_reg)
                begin
                    q_thread[ix] <= q_thread[ixp1];
                    q_dl[ix]     <= q_dl[ixp1];
                    q_fv[ix]     <= q_fv[ixp1];
                    idx_reg      <= idx_reg + TW'(1);
                end
                else
                    total_reg <= total_reg - TW'(1);
            end

            if (cmd.emit_ack)
            begin
                okind_reg  <= 1'b0;
                otid_reg   <= tid_reg;
                ost_reg    <= ack_st_reg;
                olast_reg  <= cmd.rel_last;
            end
            if (cmd.emit_rel)
            begin
                okind_reg  <= 1'b1;
                ost_reg    <= cmd.rel_status;
                olast_reg  <= cmd.rel_last;
            end
        end
    end

    // Shift phase starts at the tail; position is set when the scan ends.
    assign res.valid         = ovalid_reg;
    assign res.kind          = okind_reg;
    assign res.thread_id_out = otid_reg;
    assign res.status        = ost_reg;
    assign res.count_now     = count_reg;
    assign res.last          = olast_reg;

endmodule
`default_nettype wire

// ===== rtl/tsdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsdq_ctrl
// Controller: sequences acknowledgement, queue insertion and releases.
// ----------------------------------------------------------------------------
`default_nettype none
module tsdq_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire tsdq_pkg::dp_stat_t stat,
    output tsdq_pkg::dp_cmd_t       cmd,
    output logic                    idx_to_tail
);
    import tsdq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   rel_any;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd         = '0;
        cmd.rel_status = ST_SUCCESS;
        state_next  = state_reg;
        in_ready    = 1'b0;
        idx_to_tail = 1'b0;
        unique case (stat.act)
            ACT_SIGNAL: rel_any = stat.sig_release;
            ACT_CLOSE:  rel_any = !stat.queue_empty;
            ACT_TICK:   rel_any = stat.head_expired;
            default:    rel_any = 1'b0;
        endcase
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = !stat.out_busy;
                if (in_valid && in_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_ACK;
                end
            end
            S_ACK:
            begin
                if (stat.enqueue || (stat.act == ACT_TICK))
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
                else if (!stat.out_busy)
                begin
                    cmd.emit_ack = 1'b1;
                    cmd.rel_last = !rel_any;
                    state_next   = rel_any ? S_REL : S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    if (stat.act == ACT_TICK)
                    begin
                        cmd.tick_adjust = 1'b1;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        idx_to_tail = 1'b1;
                        state_next  = S_SHIFT;
                    end
                end
                else
                    cmd.scan_step = 1'b1;
            end
            S_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit_ack = 1'b1;
                    cmd.rel_last = !rel_any;
                    state_next   = rel_any ? S_REL : S_IDLE;
                end
            end
            S_SHIFT:
            begin
                if (stat.shift_done)
                begin
                    if (!stat.out_busy)
                    begin
                        cmd.insert   = 1'b1;
                        cmd.emit_ack = 1'b1;
                        cmd.rel_last = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else
                    cmd.shift_step = 1'b1;
            end
            S_REL:
            begin
                if (!rel_any)
                    state_next = S_IDLE;
                else if (!stat.out_busy)
                begin
                    cmd.emit_rel = 1'b1;
                    unique case (stat.act)
                        ACT_CLOSE: cmd.rel_status = ST_DEAD;
                        ACT_TICK:  cmd.rel_status = ST_TIMEOUT;
                        default:   cmd.rel_status = ST_SUCCESS;
                    endcase
                    cmd.rel_last = stat.rel_final;
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                cmd.pop = 1'b1;
                if (stat.pop_done)
                    state_next = (stat.act == ACT_SIGNAL) ? S_IDLE : S_REL;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/timed_semaphore_deadline_queue_core.sv =====
// ----------------------------------------------------------------------------
// timed_semaphore_deadline_queue_core
// Counting semaphore with a deadline-sorted wait queue.
// ----------------------------------------------------------------------------
// Usage: each action enters as one word on in_ch (valid/ready). Results
// leave on out_ch: first an acknowledgement, then any released waiters,
// with last set on the final word of the action. initial_count is written
// through cfg_we/cfg_data and is loaded by open; the user must write it only
// while the block is idle, as the block itself does not enforce this.
// A plain acknowledgement is registered in the ack state once the input
// word is latched. A tick first counts the expired waiters at the head, one
// entry a cycle, so that its acknowledgement carries the final count. A
// blocking timed wait walks the queue to its slot and shifts the tail up one
// entry per cycle; an untimed wait goes straight to the tail. Every release
// pops the head by shifting the queue one entry a cycle. These queue walks
// through the register file set the rate.
// Reset clears count, time, closed flag and the queue length; queue
// entries hold whatever until written. When out_ch stalls, the result
// word holds in the output register and the controller waits; a new
// input word is taken once the previous action is complete.
// ----------------------------------------------------------------------------
`default_nettype none
module timed_semaphore_deadline_queue_core #(
    parameter int QUEUE_DEPTH = tsdq_pkg::QueueDepthDefault
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [tsdq_pkg::InitWidth-1:0] cfg_data,
    tsdq_in_if.sink                             in_ch,
    tsdq_out_if.source                          out_ch
);
    import tsdq_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     idx_to_tail;

    tsdq_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_ch.valid),
        .in_ready    (in_ch.ready),
        .stat        (stat),
        .cmd         (cmd),
        .idx_to_tail (idx_to_tail)
    );

    tsdq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .in_action   (in_ch.action),
        .in_thread   (in_ch.thread_id),
        .in_ticks    (in_ch.wait_ticks),
        .cmd         (cmd),
        .idx_to_tail (idx_to_tail),
        .stat        (stat),
        .res         (out_ch)
    );

endmodule
`default_nettype wire

// ===== tb/tsdq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsdq_checker
// Watches both channels of the semaphore core, predicts every result word
// from the accepted input words and compares them field by field.
// ----------------------------------------------------------------------------
module tsdq_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tsdq_pkg::InitWidth-1:0] cfg_data,
    tsdq_in_if                             in_ch,
    tsdq_out_if                            out_ch,
    output int                             fail_count,
    output int                             pending
);
    import tsdq_pkg::*;

    typedef struct packed {
        logic               kind;
        logic [7:0]         tid;
        status_t            status;
        logic signed [15:0] count;
        logic               last;
    } result_word_t;

    result_word_t expected_words[$];

    // Predicted semaphore state.
    logic [14:0]        init_count;
    int                 sem_count;
    logic               closed;
    logic [47:0]        clock_ticks;
    logic [7:0]         q_tid[$];
    logic [47:0]        q_deadline[$];
    logic               q_forever[$];

    assign pending = expected_words.size();

    task automatic report(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    function automatic logic [7:0] release_head();
        logic [7:0] t;
        t = q_tid.pop_front();
        void'(q_deadline.pop_front());
        void'(q_forever.pop_front());
        return t;
    endfunction

    task automatic predict_action(input action_t act, input logic [7:0] tid,
                                  input logic [31:0] ticks);
        result_word_t words[$];
        result_word_t w;
        status_t      st;
        int           pos;
        logic [47:0]  dl;
        st = ST_SUCCESS;
        words.push_back('{1'b0, tid, ST_SUCCESS, 16'sd0, 1'b0});
        case (act)
            ACT_WAIT, ACT_TWAIT:
            begin
                if (closed)
                    st = ST_DEAD;
                else if (sem_count > 0)
                    sem_count--;
                else if (q_tid.size() >= QueueDepthDefault)
                    st = ST_FULL;
                else
                begin
                    sem_count--;
                    dl = clock_ticks + {16'd0, ticks};
                    pos = q_tid.size();
                    if (act == ACT_TWAIT)
                    begin
                        for (int i = 0; i < q_tid.size(); i++)
                        begin
                            if (q_forever[i] || dl < q_deadline[i])
                            begin
                                pos = i;
                                break;
                            end
                        end
                    end
                    q_tid.insert(pos, tid);
                    q_deadline.insert(pos, dl);
                    q_forever.insert(pos, act == ACT_WAIT);
                    st = ST_BLOCKED;
                end
            end
            ACT_SIGNAL:
            begin
                if (closed)
                    st = ST_DEAD;
                if (sem_count < 32767)
                begin
                    sem_count++;
                    if (sem_count <= 0 && q_tid.size() > 0)
                        words.push_back('{1'b1, release_head(), ST_SUCCESS, 16'sd0, 1'b0});
                end
            end
            ACT_TRY:
            begin
                if (closed)
                    st = ST_DEAD;
                else if (sem_count > 0)
                begin
                    sem_count--;
                    st = ST_UNLOCKED;
                end
            end
            ACT_CLOSE:
            begin
                closed = 1'b1;
                while (q_tid.size() > 0)
                    words.push_back('{1'b1, release_head(), ST_DEAD, 16'sd0, 1'b0});
            end
            ACT_TICK:
            begin
                clock_ticks = clock_ticks + 48'd1;
                while (q_tid.size() > 0 && !q_forever[0] && q_deadline[0] <= clock_ticks)
                begin
                    if (sem_count < 32767)
                        sem_count++;
                    words.push_back('{1'b1, release_head(), ST_TIMEOUT, 16'sd0, 1'b0});
                end
            end
            ACT_OPEN:
            begin
                sem_count = init_count;
                closed = 1'b0;
                q_tid.delete();
                q_deadline.delete();
                q_forever.delete();
            end
            default:
            begin
            end
        endcase
        words[0].status = st;
        foreach (words[k])
        begin
            w = words[k];
            w.count = sem_count[15:0];
            w.last = (k == words.size() - 1);
            expected_words.push_back(w);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_word_t exp_w;
        if (!rst_n)
        begin
            fail_count = 0;
            init_count = '0;
            sem_count = 0;
            closed = 1'b0;
            clock_ticks = '0;
            q_tid.delete();
            q_deadline.delete();
            q_forever.delete();
            expected_words.delete();
        end
        else
        begin
            // Results are checked before this edge's input word is predicted;
            // a word accepted now cannot have a result on the same edge.
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_words.size() == 0)
                    report("result word with none expected");
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (out_ch.kind !== exp_w.kind)
                        report($sformatf("kind %0b, expected %0b", out_ch.kind, exp_w.kind));
                    if (out_ch.thread_id_out !== exp_w.tid)
                        report($sformatf("thread %0d, expected %0d",
                                         out_ch.thread_id_out, exp_w.tid));
                    if (out_ch.status !== exp_w.status)
                        report($sformatf("status %0d, expected %0d",
                                         out_ch.status, exp_w.status));
                    if (out_ch.count_now !== exp_w.count)
                        report($sformatf("count %0d, expected %0d",
                                         out_ch.count_now, exp_w.count));
                    if (out_ch.last !== exp_w.last)
                        report($sformatf("last %0b, expected %0b", out_ch.last, exp_w.last));
                end
            end
            if (in_ch.valid && in_ch.ready)
                predict_action(action_t'(in_ch.action), in_ch.thread_id, in_ch.wait_ticks);
            if (cfg_we)
                init_count = cfg_data;
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the timed semaphore deadline queue core.
// ----------------------------------------------------------------------------
module testbench;
    import tsdq_pkg::*;

    // Longest action: sixteen releases, each popping the head through the queue,
    // so a generous limit covers several hundred such words with stalls.
    localparam int CycleLimit = 1000000;
    localparam int Drain = 400;

    logic            clk;
    logic            rst_n;
    logic            cfg_we;
    logic [14:0]     cfg_data;
    int              fail_count;
    int              pending;
    int              cycles;

    tsdq_in_if  in_ch();
    tsdq_out_if out_ch();

    timed_semaphore_deadline_queue_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_we  (cfg_we),
        .cfg_data(cfg_data),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source)
    );

    tsdq_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .fail_count(fail_count),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The run ends here if the block stops making progress.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("timed_semaphore_deadline_queue_core regression: fail");
            $finish;
        end
    end

    // The receiver stalls for a random number of cycles before each word,
    // and at times takes a word with no stall.
    initial
    begin
        int gap;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            repeat (gap) @(posedge clk);
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
            out_ch.ready <= 1'b0;
        end
    end

    // One word on the input channel; idle cycles come first when asked.
    // Valid stays high after the accepting edge until the next word or an
    // idle stretch replaces it.
    task automatic send_word(input action_t act, input logic [7:0] tid,
                             input logic [31:0] ticks, input bit idle);
        int gap;
        gap = idle ? $urandom_range(0, 7) : 0;
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.action <= act;
        in_ch.thread_id <= tid;
        in_ch.wait_ticks <= ticks;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // Waits until every predicted word has come, then lets the block settle.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_count(input logic [14:0] value);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_ticks();
        case ($urandom_range(0, 5))
            0: return 32'hFFFF_FFFF;
            1: return 32'd0;
            2: return $urandom();
            default: return 32'($urandom_range(0, 12));
        endcase
    endfunction

    // Mostly waits and ticks on a small count so the queue fills and drains.
    task automatic random_phase(input int words);
        action_t act;
        int      r;
        bit      idle;
        for (int n = 0; n < words; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 25)
                act = ACT_TWAIT;
            else if (r < 38)
                act = ACT_WAIT;
            else if (r < 55)
                act = ACT_SIGNAL;
            else if (r < 62)
                act = ACT_TRY;
            else if (r < 88)
                act = ACT_TICK;
            else if (r < 91)
                act = ACT_CLOSE;
            else if (r < 97)
                act = ACT_OPEN;
            else
                act = ACT_NONE;
            idle = ((n / 32) % 3 != 0);
            send_word(act, 8'($urandom_range(0, 255)), pick_ticks(), idle);
        end
    endtask

    initial
    begin
        cycles = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.action = ACT_NONE;
        in_ch.thread_id = '0;
        in_ch.wait_ticks = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: the queue fills to its depth and overflows, a tick expires
        // the short timed waiters, a signal releases the head waiter, and a
        // closed semaphore answers dead.
        write_count(15'd1);
        send_word(ACT_OPEN, 8'd0, 32'd0, 1'b0);
        send_word(ACT_TRY, 8'hFF, 32'd0, 1'b0);
        send_word(ACT_TRY, 8'h01, 32'd0, 1'b0);
        for (int i = 0; i < 8; i++)
            send_word(ACT_TWAIT, 8'(i), (i % 2) ? 32'd1 : 32'hFFFF_FFFF, 1'b1);
        for (int i = 8; i < 16; i++)
            send_word(ACT_WAIT, 8'(i), 32'd0, 1'b0);
        send_word(ACT_WAIT, 8'hAA, 32'd0, 1'b0);
        send_word(ACT_TICK, 8'h55, 32'd0, 1'b0);
        send_word(ACT_SIGNAL, 8'h12, 32'd0, 1'b0);
        send_word(ACT_NONE, 8'h34, 32'd0, 1'b0);
        send_word(ACT_CLOSE, 8'h56, 32'd0, 1'b0);
        send_word(ACT_WAIT, 8'h78, 32'd0, 1'b0);
        send_word(ACT_SIGNAL, 8'h9A, 32'd0, 1'b0);

        // Signal saturation at the top of the count.
        write_count(15'h7FFF);
        send_word(ACT_OPEN, 8'd1, 32'd0, 1'b0);
        send_word(ACT_SIGNAL, 8'd2, 32'd0, 1'b0);
        send_word(ACT_TWAIT, 8'd3, 32'h5555_AAAA, 1'b0);

        // Random phases at loaded counts 0 and 2, then after a random write.
        write_count(15'd0);
        send_word(ACT_OPEN, 8'd0, 32'd0, 1'b0);
        random_phase(140);
        write_count(15'd2);
        send_word(ACT_OPEN, 8'd0, 32'd0, 1'b0);
        random_phase(140);
        write_count(15'($urandom_range(0, 32767)));
        random_phase(130);

        wait_idle();
        repeat (Drain) @(posedge clk);
        if (fail_count == 0)
            $display("timed_semaphore_deadline_queue_core regression: pass");
        else
            $display("timed_semaphore_deadline_queue_core regression: fail");
        $finish;
    end

endmodule

// ===== timed_semaphore_deadline_queue_core.f =====
rtl/tsdq_pkg.sv
rtl/tsdq_if.sv
rtl/tsdq_dp.sv
rtl/tsdq_ctrl.sv
rtl/timed_semaphore_deadline_queue_core.sv
tb/tsdq_checker.sv
tb/testbench.sv
